// ===== design/chacha_pkg.sv =====
// shared types, constants and functions for the chacha20 stream cipher
`timescale 1ns / 1ps

package chacha_pkg;

   localparam int DOUBLE_ROUNDS_DEFAULT = 10;
   localparam int CSR_ADDR_WIDTH = 6;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [31:0] SIGMA0 = 32'h61707865;
   localparam logic [31:0] SIGMA1 = 32'h3320646e;
   localparam logic [31:0] SIGMA2 = 32'h79622d32;
   localparam logic [31:0] SIGMA3 = 32'h6b206574;

   typedef enum logic [2:0] {
      REG_KEY0 = 3'd0,
      REG_KEY1 = 3'd1,
      REG_KEY2 = 3'd2,
      REG_KEY3 = 3'd3,
      REG_NONCE0 = 3'd4,
      REG_NONCE1 = 3'd5,
      REG_INIT_CTR = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [7:0] plain_byte;
      logic last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] cipher_byte;
      logic last_out;
   } rsp_payload_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [7:0] plain_byte;
      logic last_byte;
      logic new_block;
      logic [31:0] counter;
      logic [5:0] position;
   } work_item_type;

   typedef struct packed {
      logic [255:0] key;
      logic [95:0] nonce;
   } cipher_cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINAL,
      ST_EMIT
   } back_state_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      rotl = (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [127:0] qr_mix(input logic [127:0] abcd);
      logic [31:0] a, b, c, d;
      a = abcd[127:96];
      b = abcd[95:64];
      c = abcd[63:32];
      d = abcd[31:0];
      a = a + b; d = rotl(d ^ a, 16);
      c = c + d; b = rotl(b ^ c, 12);
      a = a + b; d = rotl(d ^ a, 8);
      c = c + d; b = rotl(b ^ c, 7);
      qr_mix = {a, b, c, d};
   endfunction

endpackage

// ===== design/chacha_front.sv =====
// front part: tracks message position and block counter, classifies items
`timescale 1ns / 1ps

module chacha_front (
   input logic clock,
   input logic reset,
   input logic req_push,
   output logic req_full,
   input chacha_pkg::req_payload_type req_data,
   input logic [31:0] initial_counter,
   output logic wr_en,
   output chacha_pkg::work_item_type wr_item,
   input logic queue_full
);
   import chacha_pkg::*;

   logic in_message_ff, in_message_in;
   logic [31:0] counter_ff, counter_in;
   logic [5:0] position_ff, position_in;
   logic [31:0] cur_counter;
   logic [5:0] cur_position;

   assign req_full = queue_full;
   assign wr_en = req_push && !queue_full;
   assign cur_counter = in_message_ff ? counter_ff : initial_counter;
   assign cur_position = in_message_ff ? position_ff : 6'd0;

   always_comb begin
      wr_item.plain_byte = req_data.plain_byte;
      wr_item.last_byte = req_data.last_byte;
      wr_item.new_block = (cur_position == 6'd0);
      wr_item.counter = cur_counter;
      wr_item.position = cur_position;
      in_message_in = in_message_ff;
      counter_in = counter_ff;
      position_in = position_ff;
      if (wr_en) begin
         position_in = cur_position + 6'd1;
         counter_in = (cur_position == 6'd63) ? cur_counter + 32'd1 : cur_counter;
         in_message_in = !req_data.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_message_ff <= 1'b0;
         counter_ff <= 32'd1;
         position_ff <= 6'd0;
      end else begin
         in_message_ff <= in_message_in;
         counter_ff <= counter_in;
         position_ff <= position_in;
      end
   end

`ifndef ASSERT_OFF
   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      wr_en && !req_data.last_byte |=> position_ff == $past(cur_position) + 6'd1)
      else $error("position did not advance");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      wr_en && req_data.last_byte |=> !in_message_ff)
      else $error("message not closed after last item");
   a_wrap_count: assert property (@(posedge clock) disable iff (reset)
      wr_en && cur_position == 6'd63 && !req_data.last_byte
      |=> counter_ff == $past(cur_counter) + 32'd1)
      else $error("counter did not step at block end");
`endif

endmodule

// ===== design/chacha_queue.sv =====
// short item queue between front and back
`timescale 1ns / 1ps

module chacha_queue #(
   parameter int DEPTH = chacha_pkg::QUEUE_DEPTH
) (
   input logic clock,
   input logic reset,
   input logic wr_en,
   input chacha_pkg::work_item_type wr_item,
   output logic full,
   input logic rd_en,
   output chacha_pkg::work_item_type rd_item,
   output logic empty
);
   import chacha_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   work_item_type mem_ff [DEPTH];
   logic [AW-1:0] wptr_ff, rptr_ff;
   logic [AW:0] count_ff;

   function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
      bump = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full = (count_ff == (AW+1)'(DEPTH));
   assign empty = (count_ff == '0);
   assign rd_item = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en && !full) begin
         mem_ff[wptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (wr_en && !full) begin
            wptr_ff <= bump(wptr_ff);
         end
         if (rd_en && !empty) begin
            rptr_ff <= bump(rptr_ff);
         end
         count_ff <= count_ff + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(DEPTH))
      else $error("queue count out of range");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      wr_en && !full && !(rd_en && !empty) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not rise");
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      empty |-> wptr_ff == rptr_ff)
      else $error("pointers differ while empty");
`endif

endmodule

// ===== design/chacha_back.sv =====
// back part: keystream block generator, one quarter-round a cycle, and byte xor
`timescale 1ns / 1ps

module chacha_back #(
   parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEFAULT
) (
   input logic clock,
   input logic reset,
   input chacha_pkg::cipher_cfg_type cfg,
   input logic q_empty,
   input chacha_pkg::work_item_type q_item,
   output logic q_pop,
   output logic rsp_empty,
   input logic rsp_pop,
   output chacha_pkg::rsp_payload_type rsp_data
);
   import chacha_pkg::*;

   localparam int QR_TOTAL = 8 * DOUBLE_ROUNDS;
   localparam int QW = $clog2(QR_TOTAL);

   back_state_type state_ff, state_in;
   logic [31:0] work_ff [16];
   logic [31:0] init_ff [16];
   logic [31:0] ks_ff [16];
   logic [QW-1:0] qr_ff, qr_in;
   logic [2:0] step;
   logic [3:0] ia, ib, ic, id;
   logic [127:0] qr_out;
   logic out_valid_ff, out_valid_in;
   rsp_payload_type out_ff;
   logic load_init, do_round, do_final, do_emit;
   logic [31:0] ks_word;
   logic [7:0] ks_byte;

   assign step = qr_ff[2:0];
   always_comb begin
      unique case (step)
         3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
         3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
         3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
         3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
         3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
         3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
         3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
         default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
      endcase
   end

   assign qr_out = qr_mix({work_ff[ia], work_ff[ib], work_ff[ic], work_ff[id]});
   assign ks_word = ks_ff[q_item.position[5:2]];
   assign ks_byte = ks_word[8*q_item.position[1:0] +: 8];

   always_comb begin
      state_in = state_ff;
      qr_in = qr_ff;
      load_init = 1'b0;
      do_round = 1'b0;
      do_final = 1'b0;
      do_emit = 1'b0;
      q_pop = 1'b0;
      out_valid_in = out_valid_ff && !rsp_pop;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if (q_item.new_block) begin
                  load_init = 1'b1;
                  qr_in = '0;
                  state_in = ST_ROUND;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_ROUND: begin
            do_round = 1'b1;
            qr_in = qr_ff + 1'b1;
            if (qr_ff == QW'(QR_TOTAL - 1)) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            do_final = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!out_valid_in) begin
               do_emit = 1'b1;
               q_pop = 1'b1;
               out_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qr_ff <= qr_in;
      if (load_init) begin
         init_ff[0] <= SIGMA0; init_ff[1] <= SIGMA1;
         init_ff[2] <= SIGMA2; init_ff[3] <= SIGMA3;
         work_ff[0] <= SIGMA0; work_ff[1] <= SIGMA1;
         work_ff[2] <= SIGMA2; work_ff[3] <= SIGMA3;
         for (int i = 0; i < 8; i++) begin
            init_ff[4+i] <= cfg.key[32*i +: 32];
            work_ff[4+i] <= cfg.key[32*i +: 32];
         end
         init_ff[12] <= q_item.counter;
         work_ff[12] <= q_item.counter;
         for (int i = 0; i < 3; i++) begin
            init_ff[13+i] <= cfg.nonce[32*i +: 32];
            work_ff[13+i] <= cfg.nonce[32*i +: 32];
         end
      end else if (do_round) begin
         work_ff[ia] <= qr_out[127:96];
         work_ff[ib] <= qr_out[95:64];
         work_ff[ic] <= qr_out[63:32];
         work_ff[id] <= qr_out[31:0];
      end
      if (do_final) begin
         for (int i = 0; i < 16; i++) begin
            ks_ff[i] <= work_ff[i] + init_ff[i];
         end
      end
      if (do_emit) begin
         out_ff.cipher_byte <= q_item.plain_byte ^ ks_byte;
         out_ff.last_out <= q_item.last_byte;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data = out_ff;

`ifndef ASSERT_OFF
   a_pop_only_emit: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_EMIT && !q_empty)
      else $error("queue popped outside emit");
   a_round_to_final: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND && qr_ff == QW'(QR_TOTAL - 1) |=> state_ff == ST_FINAL)
      else $error("round count overran");
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_pop |=> out_valid_ff && $stable(out_ff))
      else $error("result changed while waiting");
`endif

endmodule

// ===== design/chacha20_stream_cipher.sv =====
// top level of the chacha20 stream cipher
`timescale 1ns / 1ps
// chacha20 (rfc 8439) stream cipher, one data byte per item.
// input queue: req_push/req_full with req_data {plain_byte, last_byte}.
// result queue: rsp_empty/rsp_pop with rsp_data {cipher_byte, last_out}.
// csr port: apb-style, 64-bit data, register i at byte address 8*i:
//   key quarters 0..3, nonce low, nonce high, initial counter.
// the front stamps each item with block counter and byte position and
// places it in a 4-entry queue; the back regenerates a keystream block
// on the first byte of every block, one quarter-round per cycle.
// a byte opening a block goes through the round, final and emit states of
// the back sequencer, other bytes from idle straight to emit; the back
// finishes each byte before it takes the next, and its pace is set by the
// shared quarter-round unit and the idle/emit steps of the back sequencer.
// reset clears the queue, output and message state; key and nonce go to
// zero and the initial counter to 1. a stalled receiver holds the result
// register, the queue then fills and req_full rises.
module chacha20_stream_cipher #(
   parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_push,
   output logic req_full,
   input chacha_pkg::req_payload_type req_data,
   output logic rsp_empty,
   input logic rsp_pop,
   output chacha_pkg::rsp_payload_type rsp_data,
   input logic psel,
   input logic penable,
   input logic pwrite,
   input logic [chacha_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic pready
);
   import chacha_pkg::*;

   logic [63:0] key0_ff, key1_ff, key2_ff, key3_ff, nonce0_ff;
   logic [31:0] nonce1_ff, init_ctr_ff;
   logic csr_write;
   logic [2:0] csr_index;
   cipher_cfg_type cfg;
   logic wr_en, q_full, q_empty, q_pop;
   work_item_type wr_item, q_item;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0; key1_ff <= '0; key2_ff <= '0; key3_ff <= '0;
         nonce0_ff <= '0; nonce1_ff <= '0; init_ctr_ff <= 32'd1;
      end else if (csr_write && paddr[2:0] == 3'd0) begin
         unique case (csr_index)
            REG_KEY0: key0_ff <= pwdata;
            REG_KEY1: key1_ff <= pwdata;
            REG_KEY2: key2_ff <= pwdata;
            REG_KEY3: key3_ff <= pwdata;
            REG_NONCE0: nonce0_ff <= pwdata;
            REG_NONCE1: nonce1_ff <= pwdata[31:0];
            REG_INIT_CTR: init_ctr_ff <= pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_KEY0: prdata = key0_ff;
         REG_KEY1: prdata = key1_ff;
         REG_KEY2: prdata = key2_ff;
         REG_KEY3: prdata = key3_ff;
         REG_NONCE0: prdata = nonce0_ff;
         REG_NONCE1: prdata = {32'd0, nonce1_ff};
         REG_INIT_CTR: prdata = {32'd0, init_ctr_ff};
         default: prdata = '0;
      endcase
   end

   assign cfg.key = {key3_ff, key2_ff, key1_ff, key0_ff};
   assign cfg.nonce = {nonce1_ff, nonce0_ff};

   chacha_front u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .initial_counter(init_ctr_ff),
      .wr_en(wr_en), .wr_item(wr_item), .queue_full(q_full)
   );

   chacha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .wr_en(wr_en), .wr_item(wr_item), .full(q_full),
      .rd_en(q_pop), .rd_item(q_item), .empty(q_empty)
   );

   chacha_back #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg),
      .q_empty(q_empty), .q_item(q_item), .q_pop(q_pop),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

endmodule
